@@ design/mdsv_pkg.sv @@
package mdsv_pkg;

	localparam int PAGE_BYTES  = 4096;
	localparam int MAX_MEMBERS = 256;

	// Wide enough to hold PAGE_BYTES itself, where the byte counter stops.
	localparam int OFF_W = $clog2(PAGE_BYTES + 1);

	localparam logic [31:0] SB_MAGIC      = 32'ha92b4efc;
	localparam logic [31:0] FEAT_RESHAPE  = 32'h0000_0004;
	localparam logic [31:0] FEAT_RECOVERY = 32'h0000_0010;
	localparam logic [31:0] MIN_CHUNK_RST = 32'd4096;

	localparam logic [OFF_W-1:0] OFF_MAGIC   = OFF_W'(12'h000);
	localparam logic [OFF_W-1:0] OFF_VERSION = OFF_W'(12'h004);
	localparam logic [OFF_W-1:0] OFF_FEATURE = OFF_W'(12'h008);
	localparam logic [OFF_W-1:0] OFF_SETID   = OFF_W'(12'h010);
	localparam logic [OFF_W-1:0] OFF_LEVEL   = OFF_W'(12'h048);
	localparam logic [OFF_W-1:0] OFF_LAYOUT  = OFF_W'(12'h04C);
	localparam logic [OFF_W-1:0] OFF_CHUNK   = OFF_W'(12'h058);
	localparam logic [OFF_W-1:0] OFF_DISKS   = OFF_W'(12'h05C);
	localparam logic [OFF_W-1:0] OFF_DATA    = OFF_W'(12'h080);
	localparam logic [OFF_W-1:0] OFF_DEVNUM  = OFF_W'(12'h0A0);
	localparam logic [OFF_W-1:0] OFF_EVENTS  = OFF_W'(12'h0C8);
	localparam logic [OFF_W-1:0] OFF_RESYNC  = OFF_W'(12'h0D0);
	localparam logic [OFF_W-1:0] OFF_ROLES   = OFF_W'(12'h100);
	localparam logic [OFF_W-1:0] PAGE_LIMIT  = OFF_W'(PAGE_BYTES);

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_MAGIC     = 4'd1,
		ST_VERSION   = 4'd2,
		ST_RESHAPE   = 4'd3,
		ST_RECOVERY  = 4'd4,
		ST_LEVEL     = 4'd5,
		ST_LAYOUT    = 4'd6,
		ST_UNSYNCED  = 4'd7,
		ST_DISKS     = 4'd8,
		ST_DEVNUM    = 4'd9,
		ST_ROLE      = 4'd10,
		ST_CHUNK     = 4'd11,
		ST_OFFSET    = 4'd12,
		ST_TRUNCATED = 4'd13
	} sb_status_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		sb_status_t  status;
		logic [3:0]  array_level;
		logic [8:0]  member_count;
		logic [7:0]  member_role;
		logic [7:0]  near_count;
		logic [7:0]  far_count;
		logic        far_offset_flag;
		logic [31:0] chunk_bytes;
		logic [63:0] data_start_bytes;
		logic [63:0] event_count_out;
		logic [63:0] set_id_high;
		logic [63:0] set_id_low;
	} result_t;

	// Fields captured from one superblock page.
	typedef struct packed {
		logic [31:0] magic;
		logic [31:0] version;
		logic [31:0] feature;
		logic [63:0] set_hi;
		logic [63:0] set_lo;
		logic [31:0] level;
		logic [31:0] layout;
		logic [31:0] chunk;
		logic [31:0] disks;
		logic [63:0] data_off;
		logic [31:0] dev_slot;
		logic [63:0] events;
		logic [63:0] resync;
		logic [15:0] role;
	} sb_fields_t;

endpackage

@@ design/md_superblock_validator_top.sv @@
// Channel   Direction  Handshake                  Word
// item      in         item_valid / item_stall    item_t: byte_value, last_byte
// result    out        result_valid / result_stall result_t: status and topology
// cfg       in         cfg_valid / cfg_ready      min_chunk_bytes (32 bits)
//
// One byte is taken every cycle while item_stall is low. A word with last_byte set
// reaches result via the snapshot register, into which the byte is merged, and the
// result register, into which the snapshot is judged. Reset clears the byte counter
// and all captured fields and sets min_chunk_bytes to 4096. item_stall rises only
// while a finished result waits in the result register under result_stall and
// another last byte is already in the snapshot register.
module md_superblock_validator_top
	import mdsv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic [31:0]       min_chunk_q;
	logic [OFF_W-1:0]  off_q;
	logic [OFF_W-1:0]  off_n;
	sb_fields_t        cap_q;
	sb_fields_t        cap_n;
	sb_fields_t        snap_s1;
	logic              trunc_s1;
	logic              valid_s1;
	logic              result_valid_q;
	result_t           result_q;
	result_t           result_d;
	logic              out_move;
	logic              item_acc;
	logic              capturing;
	logic [OFF_W-1:0]  role_rel;
	logic [7:0]        b;

	assign cfg_ready    = 1'b1;
	assign out_move     = !result_valid_q || !result_stall;
	assign item_stall   = valid_s1 && !out_move;
	assign item_acc     = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign b         = item.byte_value;
	assign capturing = off_q < PAGE_LIMIT;
	assign off_n     = capturing ? off_q + OFF_W'(1) : off_q;
	assign role_rel  = off_q - OFF_ROLES;

	// Merge the incoming byte into whichever field covers its offset.
	always_comb begin
		cap_n = cap_q;
		if (capturing) begin
			if (off_q[OFF_W-1:2] == OFF_MAGIC[OFF_W-1:2])
				cap_n.magic[{off_q[1:0], 3'b000} +: 8] = b;
			if (off_q[OFF_W-1:2] == OFF_VERSION[OFF_W-1:2])
				cap_n.version[{off_q[1:0], 3'b000} +: 8] = b;
			if (off_q[OFF_W-1:2] == OFF_FEATURE[OFF_W-1:2])
				cap_n.feature[{off_q[1:0], 3'b000} +: 8] = b;
			// The set identifier is kept big-endian within each half.
			if (off_q[OFF_W-1:4] == OFF_SETID[OFF_W-1:4]) begin
				if (off_q[3])
					cap_n.set_lo[{~off_q[2:0], 3'b000} +: 8] = b;
				else
					cap_n.set_hi[{~off_q[2:0], 3'b000} +: 8] = b;
			end
			if (off_q[OFF_W-1:2] == OFF_LEVEL[OFF_W-1:2])
				cap_n.level[{off_q[1:0], 3'b000} +: 8] = b;
			if (off_q[OFF_W-1:2] == OFF_LAYOUT[OFF_W-1:2])
				cap_n.layout[{off_q[1:0], 3'b000} +: 8] = b;
			if (off_q[OFF_W-1:2] == OFF_CHUNK[OFF_W-1:2])
				cap_n.chunk[{off_q[1:0], 3'b000} +: 8] = b;
			if (off_q[OFF_W-1:2] == OFF_DISKS[OFF_W-1:2])
				cap_n.disks[{off_q[1:0], 3'b000} +: 8] = b;
			if (off_q[OFF_W-1:3] == OFF_DATA[OFF_W-1:3])
				cap_n.data_off[{off_q[2:0], 3'b000} +: 8] = b;
			if (off_q[OFF_W-1:2] == OFF_DEVNUM[OFF_W-1:2])
				cap_n.dev_slot[{off_q[1:0], 3'b000} +: 8] = b;
			if (off_q[OFF_W-1:3] == OFF_EVENTS[OFF_W-1:3])
				cap_n.events[{off_q[2:0], 3'b000} +: 8] = b;
			if (off_q[OFF_W-1:3] == OFF_RESYNC[OFF_W-1:3])
				cap_n.resync[{off_q[2:0], 3'b000} +: 8] = b;
			// Each role slot is two bytes; only this device's slot is kept.
			if (off_q >= OFF_ROLES &&
			    cap_q.dev_slot == 32'(role_rel[OFF_W-1:1]))
				cap_n.role[{role_rel[0], 3'b000} +: 8] = b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_chunk_q <= MIN_CHUNK_RST;
			off_q       <= '0;
			cap_q       <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				min_chunk_q <= cfg_data;
			if (item_acc) begin
				if (item.last_byte) begin
					off_q <= '0;
					cap_q <= '0;
				end else begin
					off_q <= off_n;
					cap_q <= cap_n;
				end
			end
			if (item_acc && item.last_byte)
				valid_s1 <= 1'b1;
			else if (out_move)
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc && item.last_byte) begin
			snap_s1  <= cap_n;
			trunc_s1 <= off_n < PAGE_LIMIT;
		end
	end

	logic        lvl10;
	logic        lvl1;
	logic [31:0] chunk_b;
	logic [63:0] data_b;
	logic        disks_bad;
	sb_status_t  status_d;

	assign lvl10   = snap_s1.level == 32'd10;
	assign lvl1    = snap_s1.level == 32'd1;
	assign chunk_b = {snap_s1.chunk[22:0], 9'b0};
	assign data_b  = {snap_s1.data_off[54:0], 9'b0};

	always_comb begin
		if (lvl10)
			disks_bad = snap_s1.disks < 32'd4 || snap_s1.disks > 32'(MAX_MEMBERS) ||
			            snap_s1.disks[0];
		else
			disks_bad = snap_s1.disks != 32'd2;
	end

	// Checks in priority order; the first failure names the status.
	always_comb begin
		if (trunc_s1)
			status_d = ST_TRUNCATED;
		else if (snap_s1.magic != SB_MAGIC)
			status_d = ST_MAGIC;
		else if (snap_s1.version != 32'd1)
			status_d = ST_VERSION;
		else if ((snap_s1.feature & FEAT_RESHAPE) != '0)
			status_d = ST_RESHAPE;
		else if ((snap_s1.feature & FEAT_RECOVERY) != '0)
			status_d = ST_RECOVERY;
		else if (!lvl1 && !lvl10)
			status_d = ST_LEVEL;
		else if (lvl10 && (snap_s1.layout[7:0] != 8'd2 || snap_s1.layout[15:8] > 8'd1))
			status_d = ST_LAYOUT;
		else if (snap_s1.resync != '1)
			status_d = ST_UNSYNCED;
		else if (disks_bad)
			status_d = ST_DISKS;
		else if (snap_s1.dev_slot >= snap_s1.disks)
			status_d = ST_DEVNUM;
		else if (32'(snap_s1.role) >= snap_s1.disks)
			status_d = ST_ROLE;
		else if (lvl10 && (chunk_b == '0 || chunk_b < min_chunk_q))
			status_d = ST_CHUNK;
		else if (data_b == '0)
			status_d = ST_OFFSET;
		else
			status_d = ST_OK;
	end

	always_comb begin
		result_d.status           = status_d;
		result_d.array_level      = snap_s1.level[3:0];
		result_d.member_count     = snap_s1.disks[8:0];
		result_d.member_role      = snap_s1.role[7:0];
		result_d.near_count       = snap_s1.layout[7:0];
		result_d.far_count        = snap_s1.layout[15:8];
		result_d.far_offset_flag  = snap_s1.layout[16];
		result_d.chunk_bytes      = chunk_b;
		result_d.data_start_bytes = data_b;
		result_d.event_count_out  = snap_s1.events;
		result_d.set_id_high      = snap_s1.set_hi;
		result_d.set_id_low       = snap_s1.set_lo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_move) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_move && valid_s1)
			result_q <= result_d;
	end

	// A last byte always leaves a pending result behind it.
	a_last_pending: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && item.last_byte |=> valid_s1)
		else $error("last byte did not reach the snapshot stage");

	a_off_bound: assert property (@(posedge clk) disable iff (!arst_n)
		off_q <= PAGE_LIMIT)
		else $error("byte counter ran past the page");

	a_page_restart: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && item.last_byte |=> off_q == '0)
		else $error("byte counter not cleared after a page");

	a_result_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_move |=> result_valid)
		else $error("pending result was lost");

endmodule

@@ sim/testbench.sv @@
module testbench;
	import mdsv_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned PAGE_ROOM = PAGE_BYTES + 16;

	// Tracks the validator: captures each accepted byte the way the block should and
	// keeps the verdicts of finished pages until the block delivers them.
	class superblock_checker;
		logic [31:0] min_chunk;
		int unsigned offset;
		logic [31:0] magic, version, feature, level, layout, chunk, disks, dev_slot;
		logic [63:0] set_hi, set_lo, data_off, events, resync;
		logic [15:0] role;
		result_t pending[$];
		int unsigned errors;

		function new();
			min_chunk = MIN_CHUNK_RST;
			errors = 0;
			clear();
		endfunction

		function void clear();
			offset = 0;
			magic = '0;
			version = '0;
			feature = '0;
			set_hi = '0;
			set_lo = '0;
			level = '0;
			layout = '0;
			chunk = '0;
			disks = '0;
			data_off = '0;
			dev_slot = '0;
			events = '0;
			resync = '0;
			role = '0;
		endfunction

		function bit in_field(int unsigned off, int unsigned base, int unsigned n);
			return off >= base && off < base + n;
		endfunction

		function void capture(int unsigned off, logic [7:0] b);
			int unsigned r;
			if (in_field(off, OFF_MAGIC, 4)) magic[8*(off - OFF_MAGIC) +: 8] = b;
			if (in_field(off, OFF_VERSION, 4)) version[8*(off - OFF_VERSION) +: 8] = b;
			if (in_field(off, OFF_FEATURE, 4)) feature[8*(off - OFF_FEATURE) +: 8] = b;
			if (in_field(off, OFF_SETID, 16)) begin
				// The set identifier is kept with its first byte most significant.
				r = off - OFF_SETID;
				if (r < 8)
					set_hi[8*(7 - r) +: 8] = b;
				else
					set_lo[8*(15 - r) +: 8] = b;
			end
			if (in_field(off, OFF_LEVEL, 4)) level[8*(off - OFF_LEVEL) +: 8] = b;
			if (in_field(off, OFF_LAYOUT, 4)) layout[8*(off - OFF_LAYOUT) +: 8] = b;
			if (in_field(off, OFF_CHUNK, 4)) chunk[8*(off - OFF_CHUNK) +: 8] = b;
			if (in_field(off, OFF_DISKS, 4)) disks[8*(off - OFF_DISKS) +: 8] = b;
			if (in_field(off, OFF_DATA, 8)) data_off[8*(off - OFF_DATA) +: 8] = b;
			if (in_field(off, OFF_DEVNUM, 4)) dev_slot[8*(off - OFF_DEVNUM) +: 8] = b;
			if (in_field(off, OFF_EVENTS, 8)) events[8*(off - OFF_EVENTS) +: 8] = b;
			if (in_field(off, OFF_RESYNC, 8)) resync[8*(off - OFF_RESYNC) +: 8] = b;
			if (off >= OFF_ROLES) begin
				r = off - OFF_ROLES;
				if ((r >> 1) == dev_slot)
					role[8*(r & 1) +: 8] = b;
			end
		endfunction

		function sb_status_t judge(bit cut, logic [31:0] chunk_b, logic [63:0] data_b);
			bit ten;
			ten = (level == 10);
			if (cut) return ST_TRUNCATED;
			if (magic != SB_MAGIC) return ST_MAGIC;
			if (version != 1) return ST_VERSION;
			if ((feature & FEAT_RESHAPE) != 0) return ST_RESHAPE;
			if ((feature & FEAT_RECOVERY) != 0) return ST_RECOVERY;
			if (level != 1 && !ten) return ST_LEVEL;
			if (ten && (layout[7:0] != 2 || layout[15:8] > 1)) return ST_LAYOUT;
			if (!(&resync)) return ST_UNSYNCED;
			if (ten) begin
				if (disks < 4 || disks > MAX_MEMBERS || disks[0]) return ST_DISKS;
			end else if (disks != 2) begin
				return ST_DISKS;
			end
			if (dev_slot >= disks) return ST_DEVNUM;
			if (role >= disks) return ST_ROLE;
			if (ten && (chunk_b == 0 || chunk_b < min_chunk)) return ST_CHUNK;
			if (data_b == 0) return ST_OFFSET;
			return ST_OK;
		endfunction

		function void note(item_t w);
			result_t r;
			logic [31:0] chunk_b;
			logic [63:0] data_b;
			if (offset < PAGE_BYTES) begin
				capture(offset, w.byte_value);
				offset++;
			end
			if (!w.last_byte)
				return;
			chunk_b = chunk << 9;
			data_b = data_off << 9;
			r.status = judge(offset < PAGE_BYTES, chunk_b, data_b);
			r.array_level = level[3:0];
			r.member_count = disks[8:0];
			r.member_role = role[7:0];
			r.near_count = layout[7:0];
			r.far_count = layout[15:8];
			r.far_offset_flag = layout[16];
			r.chunk_bytes = chunk_b;
			r.data_start_bytes = data_b;
			r.event_count_out = events;
			r.set_id_high = set_hi;
			r.set_id_low = set_lo;
			pending.push_back(r);
			clear();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 200)
				$display("%0t mismatch: %s", $time, msg);
		endtask

		task compare(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report($sformatf("%s is %0h, expected %0h", name, got, want));
		endtask

		task check(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				report($sformatf("result word with status %0d but no page finished", got.status));
				return;
			end
			want = pending.pop_front();
			compare("status", got.status, want.status);
			compare("array_level", got.array_level, want.array_level);
			compare("member_count", got.member_count, want.member_count);
			compare("member_role", got.member_role, want.member_role);
			compare("near_count", got.near_count, want.near_count);
			compare("far_count", got.far_count, want.far_count);
			compare("far_offset_flag", got.far_offset_flag, want.far_offset_flag);
			compare("chunk_bytes", got.chunk_bytes, want.chunk_bytes);
			compare("data_start_bytes", got.data_start_bytes, want.data_start_bytes);
			compare("event_count_out", got.event_count_out, want.event_count_out);
			compare("set_id_high", got.set_id_high, want.set_id_high);
			compare("set_id_low", got.set_id_low, want.set_id_low);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] cfg_data = '0;

	superblock_checker sb = new();
	logic [7:0] page [PAGE_ROOM];
	logic idle_on = 1'b0;
	int unsigned stall_run = 0;
	int unsigned hold_count = 0;
	int unsigned cycles = 0;

	md_superblock_validator_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("** md_superblock_validator_top: FAILED **");
			$finish;
		end
	end

	// A long hold-off on the result side, counted down here once it is armed.
	always @(posedge clk) begin
		if (hold_count != 0)
			hold_count <= hold_count - 1;
	end

	always @(negedge clk) begin
		if (stall_run != 0)
			stall_run = stall_run - 1;
		else if (idle_on && $urandom_range(0, 11) == 0)
			stall_run = $urandom_range(1, 5);
		result_stall <= (hold_count != 0) || (stall_run != 0);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check(result);
	end

	function automatic void put_le(longint unsigned base, int unsigned n, logic [63:0] v);
		for (int unsigned k = 0; k < n; k++)
			page[base + k] = v[8*k +: 8];
	endfunction

	// Lays out a valid version 1 superblock with random content, then breaks the
	// check named by flaw. Wild picks the extreme variant of that flaw.
	task automatic build_page(input sb_status_t flaw, input bit ten, input bit wild);
		logic [31:0] magic, version, feat, lvl, lay, chunk, disks, dev;
		logic [63:0] data, resync;
		logic [15:0] role;
		longint unsigned slot;
		int i;
		for (i = 0; i < PAGE_ROOM; i++)
			page[i] = $urandom;
		magic = SB_MAGIC;
		version = 1;
		feat = $urandom & ~(FEAT_RESHAPE | FEAT_RECOVERY);
		lvl = ten ? 10 : 1;
		lay = $urandom;
		if (ten) begin
			lay[7:0] = 2;
			lay[15:8] = $urandom_range(0, 1);
		end
		chunk = $urandom_range(8, 2048);
		disks = ten ? 2 * $urandom_range(2, MAX_MEMBERS / 2) : 2;
		dev = $urandom_range(0, disks - 1);
		role = $urandom_range(0, disks - 1);
		data = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(1, 1 << 20));
		resync = '1;
		case (flaw)
			ST_MAGIC: magic = SB_MAGIC ^ (32'h1 << $urandom_range(0, 31));
			ST_VERSION: begin
				if (wild)
					version = 32'h8000_0001;
				else
					version = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(2, 255));
			end
			ST_RESHAPE: feat = feat | FEAT_RESHAPE | (wild ? FEAT_RECOVERY : 32'd0);
			ST_RECOVERY: feat = feat | FEAT_RECOVERY;
			ST_LEVEL: begin
				// The wild level has a low nibble of ten but is not ten.
				if (wild)
					lvl = 32'h0000_010A;
				else
					lvl = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(2, 9));
			end
			ST_LAYOUT: begin
				if (wild)
					lay[15:8] = 8'hFF;
				else
					lay[7:0] = $urandom_range(3, 255);
			end
			ST_UNSYNCED: resync = wild ? 64'd0 : ~(64'h1 << $urandom_range(0, 63));
			ST_DISKS: begin
				if (wild)
					disks = ten ? 32'hFFFF_FFFE : 32'd0;
				else if (!ten)
					disks = $urandom_range(0, 1) ? 32'd1 : 32'($urandom_range(3, 300));
				else
					case ($urandom_range(0, 2))
						0: disks = 2;
						1: disks = 2 * $urandom_range(2, 127) + 1;
						default: disks = MAX_MEMBERS + 2;
					endcase
			end
			ST_DEVNUM: begin
				// Device numbers from 1920 up put the role slot past the page.
				if (wild)
					dev = 32'hFFFF_FFFF;
				else
					dev = $urandom_range(0, 1) ? disks : 32'($urandom_range(1920, 9999));
			end
			ST_ROLE: role = wild ? 16'hFFFF : 16'($urandom_range(disks, 1023));
			ST_CHUNK: chunk = wild ? 32'h0080_0000 : 32'($urandom_range(0, 7));
			ST_OFFSET: data = wild ? 64'h0080_0000_0000_0000 : 64'd0;
			default: ;
		endcase
		put_le(OFF_MAGIC, 4, magic);
		put_le(OFF_VERSION, 4, version);
		put_le(OFF_FEATURE, 4, feat);
		put_le(OFF_LEVEL, 4, lvl);
		put_le(OFF_LAYOUT, 4, lay);
		put_le(OFF_CHUNK, 4, chunk);
		put_le(OFF_DISKS, 4, disks);
		put_le(OFF_DATA, 8, data);
		put_le(OFF_DEVNUM, 4, dev);
		put_le(OFF_RESYNC, 8, resync);
		slot = OFF_ROLES + 2 * longint'(dev);
		if (slot + 1 < PAGE_BYTES)
			put_le(slot, 2, role);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic lst);
		if (idle_on && $urandom_range(0, 15) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= '{byte_value: b, last_byte: lst};
		do
			@(posedge clk);
		while (item_stall);
		sb.note(item);
		@(negedge clk);
	endtask

	task automatic send_page(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			send_byte(page[i], i == len - 1);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_min_chunk(input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.min_chunk = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_page();
		int unsigned kind;
		sb_status_t flaw;
		kind = $urandom_range(0, 9);
		flaw = $urandom_range(0, 1) ? ST_OK : sb_status_t'($urandom_range(ST_MAGIC, ST_OFFSET));
		build_page(flaw, $urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0);
		if (kind < 5) begin
			send_page(PAGE_BYTES);
		end else if (kind < 8) begin
			send_page($urandom_range(0, 3) == 0 ? $urandom_range(1, PAGE_BYTES - 1)
				: $urandom_range(1, 300));
		end else if (kind == 8) begin
			send_page(PAGE_BYTES + $urandom_range(1, 16));
		end else begin
			for (int i = 0; i < PAGE_ROOM; i++)
				page[i] = $urandom;
			send_page(PAGE_BYTES);
		end
	endtask

	initial begin
		int k;
		int ph;
		logic [31:0] chunk_min;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		idle_on <= 1'b1;

		// Directed pages, judged against the chunk minimum left by reset.
		build_page(ST_OK, 1, 0);
		send_page(1);
		build_page(ST_OK, 1, 0);
		send_page(PAGE_BYTES);
		build_page(ST_OK, 0, 1);
		send_page(PAGE_BYTES);
		for (k = ST_MAGIC; k <= ST_OFFSET; k++) begin
			build_page(sb_status_t'(k), 1, 0);
			send_page(PAGE_BYTES);
			build_page(sb_status_t'(k), 1, 1);
			send_page(PAGE_BYTES);
		end
		build_page(ST_DISKS, 0, 1);
		send_page(PAGE_BYTES);
		build_page(ST_OK, 1, 0);
		send_page(PAGE_BYTES - 1);
		build_page(ST_OK, 1, 0);
		send_page(PAGE_ROOM);

		for (ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: chunk_min = 32'd0;
				1: chunk_min = 32'hFFFF_FFFF;
				2: chunk_min = $urandom_range(512, 1 << 20);
				3: chunk_min = $urandom;
				4: chunk_min = 32'd512;
				default: chunk_min = MIN_CHUNK_RST;
			endcase
			write_min_chunk(chunk_min);
			idle_on <= (ph != 5) && ($urandom_range(0, 3) != 0 || ph < 2);
			if (ph == 2) begin
				// Tiny pages pile up behind a held result until the input stalls.
				hold_count <= 400;
				repeat (24) begin
					build_page(ST_OK, 1, 0);
					send_page($urandom_range(1, 3));
				end
			end
			repeat (10) random_page();
		end

		drain();
		repeat (4) @(negedge clk);
		if (sb.errors == 0)
			$display("** md_superblock_validator_top: PASSED **");
		else
			$display("** md_superblock_validator_top: FAILED **");
		$finish;
	end
endmodule

@@ md_superblock_validator_top.f @@
design/mdsv_pkg.sv
design/md_superblock_validator_top.sv
sim/testbench.sv
